// File: hdl/tlcd_pkg.sv
// Shared types, widths and codes for the track line crossing detector.
`timescale 1ns / 1ps

package tlcd_pkg;

  localparam int COORD_BITS = 12;
  localparam int PTS_W      = 8;

  // Exact integer widths of the intersection terms
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * COORD_BITS;
  localparam int CROSS_W = 2 * COORD_BITS + 1;
  localparam int MUL_W   = 2 * COORD_BITS + 2;
  localparam int ABS_W   = 2 * COORD_BITS + 1;
  localparam int NUM_W   = 3 * COORD_BITS + 2;
  localparam int LHS_W   = 3 * COORD_BITS + 1;

  localparam int IN_BITS  = 4 * COORD_BITS + PTS_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BEGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BEGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_X   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_Y   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HORIZ   = 3'd4;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [PTS_W-1:0] MIN_POINTS = 8'd2;

  // Last member sits in the lowest bits
  typedef struct packed {
    logic [PTS_W-1:0]      track_points;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] start_x;
  } track_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] begin_x;
    logic [COORD_BITS-1:0] begin_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic                  horiz;
  } line_cfg_t;

  typedef struct packed {
    logic                     horiz;
    logic [1:0]               dir;
    logic                     qual;
    logic [COORD_BITS-1:0]    dom_e;
    logic [COORD_BITS-1:0]    dom_s;
    logic signed [DIFF_W-1:0] a1;
    logic signed [DIFF_W-1:0] b1;
    logic signed [DIFF_W-1:0] a2;
    logic signed [DIFF_W-1:0] b2;
    logic [PROD_W-1:0]        p_se;
    logic [PROD_W-1:0]        p_es;
    logic [PROD_W-1:0]        p_l0;
    logic [PROD_W-1:0]        p_l1;
  } s1_t;

  typedef struct packed {
    logic                      horiz;
    logic [1:0]                dir;
    logic                      qual;
    logic [COORD_BITS-1:0]     dom_e;
    logic [COORD_BITS-1:0]     dom_s;
    logic signed [DIFF_W-1:0]  a1;
    logic signed [DIFF_W-1:0]  b1;
    logic signed [DIFF_W-1:0]  a2;
    logic signed [DIFF_W-1:0]  b2;
    logic signed [CROSS_W-1:0] c1;
    logic signed [CROSS_W-1:0] c2;
    logic signed [MUL_W-1:0]   m1;
    logic signed [MUL_W-1:0]   m2;
  } s2_t;

  typedef struct packed {
    logic [1:0]              dir;
    logic                    qual;
    logic                    det_neg;
    logic [ABS_W-1:0]        abs_det;
    logic [COORD_BITS-1:0]   dom_e;
    logic [COORD_BITS-1:0]   dom_s;
    logic signed [NUM_W-1:0] pr1;
    logic signed [NUM_W-1:0] pr2;
  } s3_t;

  typedef struct packed {
    logic [1:0]              dir;
    logic                    qual;
    logic signed [NUM_W-1:0] rhs;
    logic [LHS_W-1:0]        lhs_e;
    logic [LHS_W-1:0]        lhs_s;
  } s4_t;

  typedef struct packed {
    logic [1:0] dir;
    logic       crosses;
  } result_t;

endpackage

// File: hdl/tlcd_front.sv
// Stages one and two: differences, coordinate products, cross terms, det products.
`timescale 1ns / 1ps

module tlcd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlcd_pkg::track_t    in_trk,
  input  tlcd_pkg::line_cfg_t cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output tlcd_pkg::s2_t       out_data
);
  import tlcd_pkg::*;

  s1_t  s1;
  s1_t  s1_next;
  logic s1_vld;
  s2_t  s2;
  s2_t  s2_next;
  logic s2_vld;
  logic s1_ready;
  logic s2_ready;

  assign s2_ready  = !s2_vld || out_ready;
  assign s1_ready  = !s1_vld || s2_ready;
  assign in_ready  = s1_ready;
  assign out_valid = s2_vld;
  assign out_data  = s2;

  always_comb begin
    logic in_extent;
    s1_next.horiz = cfg.horiz;
    if (cfg.horiz) begin
      s1_next.dir   = (in_trk.end_y > in_trk.start_y) ? DIR_DOWN : DIR_UP;
      s1_next.dom_e = in_trk.end_y;
      s1_next.dom_s = in_trk.start_y;
      in_extent = (in_trk.end_x <= cfg.end_x) && (in_trk.end_x >= cfg.begin_x);
    end else begin
      s1_next.dir   = (in_trk.end_x > in_trk.start_x) ? DIR_RIGHT : DIR_LEFT;
      s1_next.dom_e = in_trk.end_x;
      s1_next.dom_s = in_trk.start_x;
      in_extent = (in_trk.end_y <= cfg.end_y) && (in_trk.end_y >= cfg.begin_y);
    end
    s1_next.qual = in_extent && (in_trk.track_points >= MIN_POINTS);
    s1_next.a1   = signed'({1'b0, in_trk.end_y}) - signed'({1'b0, in_trk.start_y});
    s1_next.b1   = signed'({1'b0, in_trk.start_x}) - signed'({1'b0, in_trk.end_x});
    s1_next.a2   = signed'({1'b0, cfg.end_y}) - signed'({1'b0, cfg.begin_y});
    s1_next.b2   = signed'({1'b0, cfg.begin_x}) - signed'({1'b0, cfg.end_x});
    s1_next.p_se = PROD_W'(in_trk.start_x) * PROD_W'(in_trk.end_y);
    s1_next.p_es = PROD_W'(in_trk.start_y) * PROD_W'(in_trk.end_x);
    s1_next.p_l0 = PROD_W'(cfg.begin_x) * PROD_W'(cfg.end_y);
    s1_next.p_l1 = PROD_W'(cfg.begin_y) * PROD_W'(cfg.end_x);
  end

  always_comb begin
    s2_next.horiz = s1.horiz;
    s2_next.dir   = s1.dir;
    s2_next.qual  = s1.qual;
    s2_next.dom_e = s1.dom_e;
    s2_next.dom_s = s1.dom_s;
    s2_next.a1    = s1.a1;
    s2_next.b1    = s1.b1;
    s2_next.a2    = s1.a2;
    s2_next.b2    = s1.b2;
    // c = x0*y1 - y0*x1 for either line
    s2_next.c1    = signed'({1'b0, s1.p_se}) - signed'({1'b0, s1.p_es});
    s2_next.c2    = signed'({1'b0, s1.p_l0}) - signed'({1'b0, s1.p_l1});
    s2_next.m1    = MUL_W'(s1.a1) * MUL_W'(s1.b2);
    s2_next.m2    = MUL_W'(s1.a2) * MUL_W'(s1.b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      if (s1_ready) s1_vld <= in_valid;
      if (s2_ready) s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1 <= s1_next;
    if (s2_ready && s1_vld)   s2 <= s2_next;
  end

endmodule

// File: hdl/tlcd_isect.sv
// Stages three and four: determinant, intersection numerator, scaled track coordinates.
`timescale 1ns / 1ps

module tlcd_isect (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tlcd_pkg::s2_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tlcd_pkg::s4_t out_data
);
  import tlcd_pkg::*;

  s3_t  s3;
  s3_t  s3_next;
  logic s3_vld;
  s4_t  s4;
  s4_t  s4_next;
  logic s4_vld;
  logic s3_ready;
  logic s4_ready;

  assign s4_ready  = !s4_vld || out_ready;
  assign s3_ready  = !s3_vld || s4_ready;
  assign in_ready  = s3_ready;
  assign out_valid = s4_vld;
  assign out_data  = s4;

  always_comb begin
    logic signed [MUL_W-1:0]   diff_pos;
    logic signed [MUL_W-1:0]   diff_neg;
    logic signed [CROSS_W-1:0] ca;
    logic signed [CROSS_W-1:0] cb;
    logic signed [DIFF_W-1:0]  fa;
    logic signed [DIFF_W-1:0]  fb;
    diff_pos = in_data.m1 - in_data.m2;
    diff_neg = in_data.m2 - in_data.m1;
    s3_next.dir     = in_data.dir;
    s3_next.det_neg = in_data.m1 < in_data.m2;
    s3_next.qual    = in_data.qual && (in_data.m1 != in_data.m2);
    s3_next.abs_det = s3_next.det_neg ? ABS_W'(diff_neg) : ABS_W'(diff_pos);
    s3_next.dom_e   = in_data.dom_e;
    s3_next.dom_s   = in_data.dom_s;
    // horizontal: ny = c2*a1 - c1*a2, vertical: nx = c1*b2 - c2*b1
    if (in_data.horiz) begin
      ca = in_data.c2;
      fa = in_data.a1;
      cb = in_data.c1;
      fb = in_data.a2;
    end else begin
      ca = in_data.c1;
      fa = in_data.b2;
      cb = in_data.c2;
      fb = in_data.b1;
    end
    s3_next.pr1 = NUM_W'(ca) * NUM_W'(fa);
    s3_next.pr2 = NUM_W'(cb) * NUM_W'(fb);
  end

  always_comb begin
    s4_next.dir   = s3.dir;
    s4_next.qual  = s3.qual;
    // fold the sign of det into the numerator
    s4_next.rhs   = s3.det_neg ? (s3.pr2 - s3.pr1) : (s3.pr1 - s3.pr2);
    s4_next.lhs_e = LHS_W'(s3.dom_e) * LHS_W'(s3.abs_det);
    s4_next.lhs_s = LHS_W'(s3.dom_s) * LHS_W'(s3.abs_det);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      if (s3_ready) s3_vld <= in_valid;
      if (s4_ready) s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) s3 <= s3_next;
    if (s4_ready && s3_vld)   s4 <= s4_next;
  end

endmodule

// File: hdl/tlcd_decide.sv
// Stage five: straddle compare and the registered result beat.
`timescale 1ns / 1ps

module tlcd_decide (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlcd_pkg::s4_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tlcd_pkg::result_t out_data
);
  import tlcd_pkg::*;

  result_t res;
  result_t res_next;
  logic    res_vld;

  assign in_ready  = !res_vld || out_ready;
  assign out_valid = res_vld;
  assign out_data  = res;

  always_comb begin
    logic signed [NUM_W-1:0] le;
    logic signed [NUM_W-1:0] ls;
    logic                    rising;
    logic                    straddle;
    le = signed'({1'b0, in_data.lhs_e});
    ls = signed'({1'b0, in_data.lhs_s});
    rising = (in_data.dir == DIR_DOWN) || (in_data.dir == DIR_RIGHT);
    if (rising) straddle = (le > in_data.rhs) && (ls < in_data.rhs);
    else        straddle = (le < in_data.rhs) && (ls > in_data.rhs);
    res_next.dir     = in_data.dir;
    res_next.crosses = in_data.qual && straddle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (in_ready) begin
      res_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) res <= res_next;
  end

endmodule

// File: hdl/track_line_crossing_detector.sv
// Top level of the track line crossing detector: config registers and pipeline.
`timescale 1ns / 1ps

// Tests one track (first and last position, point count) against a counting line.
// Slave side: one beat per track on s_axis_*; master side: one result beat per
// track on m_axis_*, in the same order. Line registers are written on the cfg_*
// port: cfg_wen high at a rising edge stores cfg_data into register cfg_index
// (0 begin x, 1 begin y, 2 end x, 3 end y, 4 horizontal flag); other indexes drop.
// Write them only while no track is in flight.
// The result passes through five register stages (front s1 and s2, intersect s3
// and s4, decide result) after its beat is accepted, each holding at most one
// multiply or one wide subtract and compare. Throughput: one beat per cycle
// while m_axis_tready stays high.
// Every stage carries its own valid bit and advances whenever the stage after
// it is empty or moving, so when the receiver holds m_axis_tready low the
// pipeline fills bubbles first and only then drops s_axis_tready.
// Reset clears every valid bit and loads the line registers with begin and end
// at the origin and the horizontal flag set.
module track_line_crossing_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_x, start_y, end_x, end_y, track_points, zero fill
  input  logic [tlcd_pkg::IN_W-1:0]        s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // crosses, moving_direction[1:0], zero fill
  output logic [tlcd_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                             cfg_wen,
  input  logic [tlcd_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [tlcd_pkg::COORD_BITS-1:0]  cfg_data
);
  import tlcd_pkg::*;

  line_cfg_t line_cfg;
  track_t    trk;
  s2_t       front_data;
  logic      front_valid;
  logic      front_ready;
  s4_t       isect_data;
  logic      isect_valid;
  logic      isect_ready;
  result_t   res;

  // Hold the counting line; only the horizontal flag resets to one
  always_ff @(posedge clk) begin
    if (rst) begin
      line_cfg <= '{begin_x: '0, begin_y: '0, end_x: '0, end_y: '0, horiz: 1'b1};
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BEGIN_X: line_cfg.begin_x <= cfg_data;
        REG_BEGIN_Y: line_cfg.begin_y <= cfg_data;
        REG_END_X:   line_cfg.end_x   <= cfg_data;
        REG_END_Y:   line_cfg.end_y   <= cfg_data;
        REG_HORIZ:   line_cfg.horiz   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the track beat; start_x sits in the lowest bits
  assign trk = s_axis_tdata[IN_BITS-1:0];

  tlcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_trk    (trk),
    .cfg       (line_cfg),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  tlcd_isect u_isect (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (isect_valid),
    .out_ready (isect_ready),
    .out_data  (isect_data)
  );

  tlcd_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (isect_valid),
    .in_ready  (isect_ready),
    .in_data   (isect_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  // Pad the result beat to a whole byte
  assign m_axis_tdata = OUT_W'(res);

endmodule
